// ===== rtl/rqs_pkg.sv =====
// Shared types, constants and codes for the ready queue scheduler.
`timescale 1ns / 1ps

package rqs_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;

  localparam int ID_W       = 6;
  localparam int KEY_W      = 16;
  localparam int QUANTUM_W  = 8;
  localparam int OCC_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // id in the lowest bits, then length, deadline, remaining
  typedef struct packed {
    logic [KEY_W-1:0] remaining;
    logic [KEY_W-1:0] deadline;
    logic [KEY_W-1:0] length;
    logic [ID_W-1:0]  id;
  } task_t;

  localparam int TASK_W      = $bits(task_t);
  localparam int IN_DATA_W   = ((TASK_W + 7) / 8) * 8;

  // granted_task in the lowest bits, then grant, finished, preemptions, occupancy
  typedef struct packed {
    logic [OCC_W-1:0] occupancy;
    logic [KEY_W-1:0] preemptions;
    logic             finished;
    logic [KEY_W-1:0] grant;
    logic [ID_W-1:0]  granted_task;
  } res_t;

  localparam int RES_W      = $bits(res_t);
  localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - RES_W;

  typedef enum logic [1:0] {
    ST_INSERTED   = 2'd0,
    ST_DROPPED    = 2'd1,
    ST_DISPATCHED = 2'd2,
    ST_EMPTY      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ORD_FIFO     = 2'd0,
    ORD_LENGTH   = 2'd1,
    ORD_DEADLINE = 2'd2
  } order_t;

  typedef enum logic [1:0] {
    POL_WHOLE   = 2'd0,
    POL_QUANTUM = 2'd1,
    POL_MARGIN  = 2'd2
  } policy_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUEUE_ORDER  = 2'd0,
    REG_GRANT_POLICY = 2'd1,
    REG_QUANTUM      = 2'd2,
    REG_MARGIN_LIMIT = 2'd3
  } cfg_reg_t;

  localparam logic        MODE_INSERT   = 1'b0;
  localparam logic        MODE_DISPATCH = 1'b1;

  typedef struct packed {
    logic [1:0]           queue_order;
    logic [1:0]           grant_policy;
    logic [QUANTUM_W-1:0] quantum;
    logic [KEY_W-1:0]     margin_limit;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_INS_START,
    S_FIND,
    S_SCAN,
    S_INS_WR,
    S_DISP
  } ctrl_state_t;

  typedef struct packed {
    logic    load;       // latch the accepted item
    logic    pos_init;   // insert position at the tail, search index at the head
    logic    rd_head;    // read the head entry
    logic    rd_find;    // read the entry at the search index
    logic    find_step;  // search index moves one entry on
    logic    rd_scan;    // read the entry just below the insert position
    logic    shift;      // move the read entry one place up
    logic    write_new;  // write the new task at the insert position
    logic    pop;        // remove the head and commit the grant
    logic    res_load;   // load the output register
    status_t res_kind;
  } cmd_t;

  typedef struct packed {
    logic is_dispatch;
    logic full;
    logic empty;
    logic sorted;
    logic pos_zero;
    logic pos_tgt;       // insert position is one above the search index
    logic find_last;     // search index is on the last queued entry
    logic key_ge;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/ready_queue_scheduler.sv =====
// Ready queue scheduler top level: configuration registers and unit wiring.
`timescale 1ns / 1ps

// Bounded ready queue of up to QUEUE_DEPTH tasks with a time-slice grant unit.
// in_tuser selects the item: 0 inserts the task carried in in_tdata, 1 pops
// the head and grants it a slice. Inserts go to the tail (FIFO) or ahead of
// the first entry, counted from the head, whose job length or deadline is not
// smaller, as set by queue_order. Grants follow grant_policy: the whole
// remainder, the quantum clipped to the remainder, or the deadline-margin rule
// against a saturating 16-bit virtual clock that moves only under that rule.
// Every item yields exactly one result: out_tuser gives the status (inserted,
// dropped because full, dispatched, queue empty). One item is worked on at a
// time. A sorted insert first walks from the head comparing one entry per
// cycle, then moves the entries from the tail down to the insert point up one
// place, one per cycle. The queue memory can do one read and one write per
// cycle. The queue is circular, so a dispatch moves only the head pointer.
// The input side reopens the cycle after the result is loaded; a stalled sink
// holds the block until the output register is free. Queue storage, the
// insert and search indices and the item and result registers have no reset;
// only the head pointer, count, virtual clock, preemption counter, output
// valid flag and configuration clear. Configuration writes are always
// accepted and must come while the block is idle.

module ready_queue_scheduler import rqs_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_tuser,    // mode
  input  logic [IN_DATA_W-1:0]  in_tdata,    // task_id, job_length, deadline, remaining
  // results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [1:0]            out_tuser,   // status
  output logic [OUT_DATA_W-1:0] out_tdata,   // granted_task, grant, finished,
                                             // preemptions, occupancy
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  cmd_t cmd;
  sts_t sts;

  // config registers; every index maps onto one register
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_QUEUE_ORDER:  cfg_nxt.queue_order  = cfg_data[1:0];
        REG_GRANT_POLICY: cfg_nxt.grant_policy = cfg_data[1:0];
        REG_QUANTUM:      cfg_nxt.quantum      = cfg_data[QUANTUM_W-1:0];
        REG_MARGIN_LIMIT: cfg_nxt.margin_limit = cfg_data[KEY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.queue_order  <= ORD_FIFO;
      cfg_r.grant_policy <= POL_QUANTUM;
      cfg_r.quantum      <= QUANTUM_W'(1);
      cfg_r.margin_limit <= KEY_W'(10);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rqs_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg        (cfg_r),
    .item_mode  (in_tuser),
    .item_task  (task_t'(in_tdata[TASK_W-1:0])),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  // one item at a time: after an accept the input side is closed
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item accepted while another is in flight");

  // a result never overwrites one the sink has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> sts.out_free)
    else $error("output register overwritten");

  // a task is never written into a full queue
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_new |-> !sts.full)
    else $error("insert into full queue");

  // entries only move during a sorted insert with entries below the slot
  a_shift_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift |-> (sts.sorted && !sts.pos_zero))
    else $error("entry shifted outside a sorted insert");
`endif

endmodule

// ===== rtl/rqs_ctrl.sv =====
// Controller state machine of the ready queue scheduler.
`timescale 1ns / 1ps

module rqs_ctrl import rqs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.is_dispatch) begin
          if (!sts.empty) state_nxt = S_DISP;
          else if (sts.out_free) state_nxt = S_IDLE;
        end else if (!sts.full) begin
          state_nxt = S_INS_START;
        end else if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_INS_START: begin
        state_nxt = (sts.sorted && !sts.pos_zero) ? S_FIND : S_INS_WR;
      end
      S_FIND: begin
        if (sts.key_ge) state_nxt = S_SCAN;
        else if (sts.find_last) state_nxt = S_INS_WR;
      end
      S_SCAN: begin
        if (sts.pos_tgt) state_nxt = S_INS_WR;
      end
      S_INS_WR, S_DISP: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.res_kind = ST_INSERTED;
    in_tready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_DECIDE: begin
        if (sts.is_dispatch) begin
          if (!sts.empty) begin
            cmd.rd_head = 1'b1;
          end else begin
            cmd.res_load = sts.out_free;
            cmd.res_kind = ST_EMPTY;
          end
        end else if (!sts.full) begin
          cmd.pos_init = 1'b1;
        end else begin
          cmd.res_load = sts.out_free;
          cmd.res_kind = ST_DROPPED;
        end
      end
      S_INS_START: begin
        cmd.rd_find = sts.sorted && !sts.pos_zero;
      end
      S_FIND: begin
        if (sts.key_ge) begin
          // insert point found: start moving entries up from the tail
          cmd.rd_scan = 1'b1;
        end else begin
          cmd.find_step = 1'b1;
          cmd.rd_find   = !sts.find_last;
        end
      end
      S_SCAN: begin
        cmd.shift   = 1'b1;
        cmd.rd_scan = !sts.pos_tgt;
      end
      S_INS_WR: begin
        cmd.write_new = sts.out_free;
        cmd.res_load  = sts.out_free;
        cmd.res_kind  = ST_INSERTED;
      end
      S_DISP: begin
        cmd.pop      = sts.out_free;
        cmd.res_load = sts.out_free;
        cmd.res_kind = ST_DISPATCHED;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/rqs_datapath.sv =====
// Datapath: queue memory, pointers, grant unit and output register.
`timescale 1ns / 1ps

module rqs_datapath import rqs_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  cfg_t                  cfg,
  input  logic                  item_mode,
  input  task_t                 item_task,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [1:0]            out_tuser,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;

  // circular index: base plus offset, wrapped once
  function automatic logic [ADDR_W-1:0] wrap(input logic [ADDR_W-1:0] base,
                                             input logic [CNT_W-1:0]  off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(QUEUE_DEPTH)) sum = sum - SUM_W'(QUEUE_DEPTH);
    return sum[ADDR_W-1:0];
  endfunction

  task_t queue_mem [QUEUE_DEPTH];
  task_t rdata_r;

  logic              mode_r;
  task_t             item_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  fidx_r, fidx_nxt;
  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [KEY_W-1:0]  vclk_r, vclk_nxt;
  logic [KEY_W-1:0]  preempt_r, preempt_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r;
  res_t              res_r;

  logic [CNT_W-1:0]  pos_eff;
  logic [CNT_W-1:0]  fidx_eff;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              rd_en, wr_en;
  task_t             wr_data;
  logic [KEY_W-1:0]  key_mem, key_item;

  logic signed [KEY_W:0] margin;
  logic [KEY_W:0]        g_raw;
  logic [KEY_W-1:0]      grant_v;
  logic                  fin_v;
  logic [KEY_W:0]        vsum;
  res_t                  res_nxt;

  // ---- queue memory ----
  assign pos_eff  = cmd.shift ? pos_r - CNT_W'(1) : pos_r;
  assign fidx_eff = cmd.find_step ? fidx_r + CNT_W'(1) : fidx_r;
  assign rd_en    = cmd.rd_head || cmd.rd_find || cmd.rd_scan;
  assign rd_addr  = cmd.rd_head ? head_r :
                    cmd.rd_find ? wrap(head_r, fidx_eff) :
                                  wrap(head_r, pos_eff - CNT_W'(1));
  assign wr_en    = cmd.shift || cmd.write_new;
  assign wr_addr  = wrap(head_r, pos_r);
  assign wr_data  = cmd.shift ? rdata_r : item_r;

  always_ff @(posedge clk) begin
    if (wr_en) queue_mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= queue_mem[rd_addr];
  end

  // ---- ordering key ----
  assign key_mem  = (cfg.queue_order == ORD_LENGTH) ? rdata_r.length : rdata_r.deadline;
  assign key_item = (cfg.queue_order == ORD_LENGTH) ? item_r.length : item_r.deadline;

  // ---- grant unit, works on the head entry in rdata_r ----
  assign margin = $signed({1'b0, rdata_r.deadline}) - $signed({1'b0, vclk_r});

  always_comb begin
    case (cfg.grant_policy)
      POL_WHOLE: g_raw = {1'b0, rdata_r.remaining};
      POL_MARGIN: begin
        if (margin <= $signed({1'b0, rdata_r.remaining})) begin
          g_raw = {1'b0, rdata_r.remaining};
        end else if (margin < $signed({1'b0, cfg.margin_limit})) begin
          g_raw = (KEY_W + 1)'({cfg.quantum, 1'b0});
        end else begin
          g_raw = (KEY_W + 1)'(cfg.quantum);
        end
      end
      default: g_raw = (KEY_W + 1)'(cfg.quantum);
    endcase
  end

  assign grant_v = (g_raw > {1'b0, rdata_r.remaining}) ? rdata_r.remaining
                                                       : g_raw[KEY_W-1:0];
  assign fin_v   = (grant_v >= rdata_r.remaining);
  assign vsum    = {1'b0, vclk_r} + {1'b0, grant_v};

  // ---- state update ----
  always_comb begin
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    fidx_nxt    = fidx_r;
    head_nxt    = head_r;
    vclk_nxt    = vclk_r;
    preempt_nxt = preempt_r;
    if (cmd.pos_init) begin
      pos_nxt  = count_r;
      fidx_nxt = '0;
    end
    if (cmd.find_step) fidx_nxt = fidx_r + CNT_W'(1);
    if (cmd.shift) pos_nxt = pos_r - CNT_W'(1);
    if (cmd.write_new) count_nxt = count_r + CNT_W'(1);
    if (cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
      head_nxt  = wrap(head_r, CNT_W'(1));
      if (cfg.grant_policy == POL_MARGIN) begin
        vclk_nxt = vsum[KEY_W] ? '1 : vsum[KEY_W-1:0];
      end
      if (!fin_v && (preempt_r != '1)) preempt_nxt = preempt_r + KEY_W'(1);
    end
  end

  always_comb begin
    res_nxt             = '0;
    res_nxt.occupancy   = OCC_W'(count_nxt);
    res_nxt.preemptions = preempt_nxt;
    if (cmd.res_kind == ST_DISPATCHED) begin
      res_nxt.granted_task = rdata_r.id;
      res_nxt.grant        = grant_v;
      res_nxt.finished     = fin_v;
    end
  end

  assign out_valid_nxt = cmd.res_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      head_r      <= '0;
      vclk_r      <= '0;
      preempt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      vclk_r      <= vclk_nxt;
      preempt_r   <= preempt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    fidx_r <= fidx_nxt;
    if (cmd.load) begin
      mode_r <= item_mode;
      item_r <= item_task;
    end
    if (cmd.res_load) begin
      res_r        <= res_nxt;
      out_status_r <= cmd.res_kind;
    end
  end

  // ---- status to the controller ----
  assign sts.is_dispatch = (mode_r == MODE_DISPATCH);
  assign sts.full        = (count_r == CNT_W'(QUEUE_DEPTH));
  assign sts.empty       = (count_r == '0);
  assign sts.sorted      = (cfg.queue_order == ORD_LENGTH) ||
                           (cfg.queue_order == ORD_DEADLINE);
  assign sts.pos_zero    = (pos_r == '0);
  assign sts.pos_tgt     = (pos_r == fidx_r + CNT_W'(1));
  assign sts.find_last   = (fidx_r + CNT_W'(1) == count_r);
  assign sts.key_ge      = (key_mem >= key_item);
  assign sts.out_free    = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, res_r};

endmodule
